### hdl/pgs_pkg.sv
// Shared types, constants and a helper function for the peak-gated speech segmenter.
package pgs_pkg;

    localparam int BLOCK_MAX = 1024;
    localparam int CNT_W     = $clog2(BLOCK_MAX + 1);

    localparam int SAMPLE_W = 16;
    localparam int PEAK_W   = 15;
    localparam int QUIET_W  = 8;
    localparam int SEGLEN_W = 20;
    localparam int CAUSE_W  = 2;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam logic [PEAK_W-1:0]   THRESHOLD_RESET   = PEAK_W'(200);
    localparam logic [QUIET_W-1:0]  SILENCE_END_RESET = QUIET_W'(15);
    localparam logic [SEGLEN_W-1:0] MAX_SEG_RESET     = SEGLEN_W'(80000);

    localparam logic [QUIET_W-1:0]  QUIET_MAX = '1;

    // Register indexes, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_PEAK_THRESHOLD      = 2'd0,
        REG_SILENCE_END_BLOCKS  = 2'd1,
        REG_MAX_SEGMENT_SAMPLES = 2'd2,
        REG_UNUSED              = 2'd3
    } reg_index_t;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_SILENCE = 2'd1,
        CAUSE_LENGTH  = 2'd2
    } end_cause_t;

    typedef struct packed {
        logic [PEAK_W-1:0]   peak_threshold;
        logic [QUIET_W-1:0]  silence_end_blocks;
        logic [SEGLEN_W-1:0] max_segment_samples;
    } cfg_t;

    typedef struct packed {
        logic [PEAK_W-1:0] peak;
        logic [CNT_W-1:0]  count;
    } block_info_t;

    typedef struct packed {
        logic [PEAK_W-1:0]   block_peak;
        logic [CNT_W-1:0]    take_count;
        logic                segment_start;
        logic                segment_end;
        end_cause_t          end_cause;
        logic [SEGLEN_W-1:0] segment_length;
    } result_t;

    // Absolute value of a 16-bit sample; the magnitude of the most negative
    // value saturates to the largest positive one.
    function automatic logic [PEAK_W-1:0] abs_sat(input logic [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] mag;
        mag = s[SAMPLE_W-1] ? (~s + SAMPLE_W'(1)) : s;
        return mag[SAMPLE_W-1] ? {PEAK_W{1'b1}} : mag[PEAK_W-1:0];
    endfunction

endpackage

### hdl/pgs_regs.sv
// APB configuration registers of the segmenter.
module pgs_regs
    import pgs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t idx;
    logic       wr_en;

    assign idx    = reg_index_t'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_PEAK_THRESHOLD:
                    cfg_next.peak_threshold = pwdata[PEAK_W-1:0];
                REG_SILENCE_END_BLOCKS:
                    cfg_next.silence_end_blocks = pwdata[QUIET_W-1:0];
                REG_MAX_SEGMENT_SAMPLES:
                    cfg_next.max_segment_samples = pwdata[SEGLEN_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_PEAK_THRESHOLD:
                prdata = APB_DATA_W'(cfg_reg.peak_threshold);
            REG_SILENCE_END_BLOCKS:
                prdata = APB_DATA_W'(cfg_reg.silence_end_blocks);
            REG_MAX_SEGMENT_SAMPLES:
                prdata = APB_DATA_W'(cfg_reg.max_segment_samples);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.peak_threshold      <= THRESHOLD_RESET;
            cfg_reg.silence_end_blocks  <= SILENCE_END_RESET;
            cfg_reg.max_segment_samples <= MAX_SEG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/pgs_peak_tracker.sv
// Per-block running peak and sample count.
module pgs_peak_tracker
    import pgs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                block_last,
    output block_info_t         blk
);

    logic [PEAK_W-1:0] peak_reg;
    logic [PEAK_W-1:0] peak_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic [PEAK_W-1:0] mag;
    logic              room;

    assign mag  = abs_sat(sample);
    // Samples past the block size limit are dropped.
    assign room = (fill_reg < CNT_W'(BLOCK_MAX));

    always_comb begin
        blk.peak  = peak_reg;
        blk.count = fill_reg;
        if (room) begin
            if (mag > peak_reg) begin
                blk.peak = mag;
            end
            blk.count = fill_reg + CNT_W'(1);
        end
    end

    always_comb begin
        peak_next = peak_reg;
        fill_next = fill_reg;
        if (advance) begin
            if (block_last) begin
                peak_next = '0;
                fill_next = '0;
            end else begin
                peak_next = blk.peak;
                fill_next = blk.count;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg <= '0;
            fill_reg <= '0;
        end else begin
            peak_reg <= peak_next;
            fill_reg <= fill_next;
        end
    end

endmodule

### hdl/pgs_segment_ctrl.sv
// Segment open/close decision made at each block end.
module pgs_segment_ctrl
    import pgs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        block_done,
    input  block_info_t blk,
    input  cfg_t        cfg,
    output result_t     res
);

    logic                active_reg;
    logic                active_next;
    logic [SEGLEN_W-1:0] fill_reg;
    logic [SEGLEN_W-1:0] fill_next;
    logic [QUIET_W-1:0]  quiet_reg;
    logic [QUIET_W-1:0]  quiet_next;

    logic                speech;
    logic                active_now;
    logic [QUIET_W-1:0]  quiet_now;
    logic                full;
    logic [SEGLEN_W-1:0] remain;
    logic [SEGLEN_W-1:0] n_ext;
    logic [SEGLEN_W-1:0] take;
    logic [SEGLEN_W-1:0] fill_new;
    end_cause_t          cause;

    assign speech     = (blk.peak >= cfg.peak_threshold);
    assign active_now = active_reg | speech;

    always_comb begin
        if (speech) begin
            quiet_now = '0;
        end else if (active_reg && quiet_reg != QUIET_MAX) begin
            quiet_now = quiet_reg + QUIET_W'(1);
        end else begin
            quiet_now = quiet_reg;
        end
    end

    // The segment fill is zero whenever no segment is active.
    assign full   = (fill_reg >= cfg.max_segment_samples);
    assign remain = cfg.max_segment_samples - fill_reg;
    assign n_ext  = SEGLEN_W'(blk.count);

    always_comb begin
        if (!active_now || full) begin
            take = '0;
        end else if (n_ext > remain) begin
            take = remain;
        end else begin
            take = n_ext;
        end
    end

    assign fill_new = fill_reg + take;

    always_comb begin
        if (!active_now) begin
            cause = CAUSE_NONE;
        end else if (quiet_now >= cfg.silence_end_blocks) begin
            cause = CAUSE_SILENCE;
        end else if (fill_new >= cfg.max_segment_samples) begin
            cause = CAUSE_LENGTH;
        end else begin
            cause = CAUSE_NONE;
        end
    end

    always_comb begin
        res.block_peak     = blk.peak;
        res.take_count     = take[CNT_W-1:0];
        res.segment_start  = speech & ~active_reg;
        res.segment_end    = (cause != CAUSE_NONE);
        res.end_cause      = cause;
        res.segment_length = fill_new;
    end

    always_comb begin
        active_next = active_reg;
        fill_next   = fill_reg;
        quiet_next  = quiet_reg;
        if (block_done) begin
            if (res.segment_end) begin
                active_next = 1'b0;
                fill_next   = '0;
                quiet_next  = '0;
            end else begin
                active_next = active_now;
                fill_next   = fill_new;
                quiet_next  = quiet_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            fill_reg   <= '0;
            quiet_reg  <= '0;
        end else begin
            active_reg <= active_next;
            fill_reg   <= fill_next;
            quiet_reg  <= quiet_next;
        end
    end

endmodule

### hdl/peak_gated_speech_segmenter.sv
// Top level of the peak-gated speech segmenter: sample input, block results, APB registers.
//
//   channel  direction  handshake           payload
//   s_       in         s_valid / s_ready   s_sample, s_block_last
//   m_       out        m_valid / m_ready   m_block_peak, m_take_count, m_segment_start,
//                                           m_segment_end, m_end_cause, m_segment_length
//   apb      in/out     psel/penable/pready paddr, pwdata, prdata
//
// Each sample beat is captured in an input register and then folded into the
// block state, so one beat is taken every cycle unless a block-last beat is
// waiting. A block-last beat loads its result into the output register when
// it leaves the input register. Only a block-last beat waits in the input register, and
// only while the output register holds a result not yet taken. Reset clears
// the block and segment state and loads the registers with their defaults.
module peak_gated_speech_segmenter
    import pgs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [SAMPLE_W-1:0]   s_sample,
    input  logic                  s_block_last,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PEAK_W-1:0]     m_block_peak,
    output logic [CNT_W-1:0]      m_take_count,
    output logic                  m_segment_start,
    output logic                  m_segment_end,
    output logic [CAUSE_W-1:0]    m_end_cause,
    output logic [SEGLEN_W-1:0]   m_segment_length,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t        cfg;
    block_info_t blk;
    result_t     res;

    // Input register.
    logic                in_valid_reg;
    logic                in_valid_next;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic                in_last_reg;

    // Output register.
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;

    logic advance;
    logic block_done;
    logic accept;

    // A held beat moves on unless it would produce a result while the
    // output register is still occupied.
    assign advance    = in_valid_reg & ~(in_last_reg & out_valid_reg & ~m_ready);
    assign block_done = advance & in_last_reg;
    assign s_ready    = ~in_valid_reg | advance;
    assign accept     = s_valid & s_ready;

    pgs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pgs_peak_tracker u_peak (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .sample     (in_sample_reg),
        .block_last (in_last_reg),
        .blk        (blk)
    );

    pgs_segment_ctrl u_seg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .block_done (block_done),
        .blk        (blk),
        .cfg        (cfg),
        .res        (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (block_done) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_sample_reg <= s_sample;
            in_last_reg   <= s_block_last;
        end
        if (block_done) begin
            out_reg <= res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_block_peak     = out_reg.block_peak;
    assign m_take_count     = out_reg.take_count;
    assign m_segment_start  = out_reg.segment_start;
    assign m_segment_end    = out_reg.segment_end;
    assign m_end_cause      = out_reg.end_cause;
    assign m_segment_length = out_reg.segment_length;

endmodule
